// ----- design/y2b_pkg.sv -----
// Shared types and constants for the YUV 4:2:0 to BGR converter.
// Used by y2b_front, y2b_fifo, y2b_back and yuv420_to_bgr_converter.
package y2b_pkg;

	localparam int PPL_W     = 10;
	localparam int FH_W      = 11;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;

	localparam int MAX_PAIRS_DEF = 512;
	localparam int MAX_LINES_DEF = 1024;
	localparam int PPL_RESET     = 320;
	localparam int FH_RESET      = 480;

	localparam int FIFO_DEPTH = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAIRS_PER_LINE = 1'b0,
		REG_FRAME_HEIGHT   = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] luma_first;
		logic [7:0] luma_second;
		logic [7:0] chroma_u;
		logic [7:0] chroma_v;
	} yuv_item_t;

	typedef struct packed {
		logic [7:0] blue_first;
		logic [7:0] green_first;
		logic [7:0] red_first;
		logic [7:0] blue_second;
		logic [7:0] green_second;
		logic [7:0] red_second;
		logic       end_of_line;
		logic       end_of_frame;
	} bgr_item_t;

	// Pair with its resolved chroma and position flags, front to back
	typedef struct packed {
		logic [7:0] luma_first;
		logic [7:0] luma_second;
		logic [7:0] chroma_u;
		logic [7:0] chroma_v;
		logic       end_of_line;
		logic       end_of_frame;
	} pair_item_t;

endpackage

// ----- design/y2b_front.sv -----
// Front end: configuration registers, raster position counters and chroma line store.
// Depends on y2b_pkg.
module y2b_front import y2b_pkg::*; #(
	parameter int MAX_PAIRS = MAX_PAIRS_DEF,
	parameter int MAX_LINES = MAX_LINES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 push,
	output logic                 full,
	input  yuv_item_t            yuv,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pair_item_t           out_item
);

	localparam int CW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
	localparam int RW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

	function automatic logic [CW-1:0] last_col_of(input logic [PPL_W-1:0] v);
		int p;
		p = int'(v);
		if (p < 1) p = 1;
		if (p > MAX_PAIRS) p = MAX_PAIRS;
		return CW'(p - 1);
	endfunction

	function automatic logic [RW-1:0] last_row_of(input logic [FH_W-1:0] v);
		int p;
		p = int'(v);
		if (p < 1) p = 1;
		if (p > MAX_LINES) p = MAX_LINES;
		return RW'(p - 1);
	endfunction

	logic [CW-1:0] last_col_q;
	logic [RW-1:0] last_row_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic [15:0]   chroma_mem [MAX_PAIRS];
	logic [15:0]   chroma_rd_q;

	logic          valid_s1;
	logic          odd_s1;
	pair_item_t    item_s1;

	logic          accept;
	logic          eol;
	logic          eof;
	logic [CW-1:0] addr;

	assign full   = valid_s1 && !out_ready;
	assign accept = push && !full;

	// A counter beyond the last position counts as the last position
	assign eol  = (col_q >= last_col_q);
	assign eof  = eol && (row_q >= last_row_q);
	assign addr = eol ? last_col_q : col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= last_col_of(PPL_W'(PPL_RESET));
			last_row_q <= last_row_of(FH_W'(FH_RESET));
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PAIRS_PER_LINE: last_col_q <= last_col_of(cfg_data[PPL_W-1:0]);
				REG_FRAME_HEIGHT:   last_row_q <= last_row_of(cfg_data[FH_W-1:0]);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (eol) begin
				col_q <= '0;
				row_q <= eof ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Even rows store their chroma, odd rows read it back
	always_ff @(posedge clk) begin
		if (accept) begin
			if (!row_q[0]) begin
				chroma_mem[addr] <= {yuv.chroma_u, yuv.chroma_v};
			end else begin
				chroma_rd_q <= chroma_mem[addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (out_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			odd_s1               <= row_q[0];
			item_s1.luma_first   <= yuv.luma_first;
			item_s1.luma_second  <= yuv.luma_second;
			item_s1.chroma_u     <= yuv.chroma_u;
			item_s1.chroma_v     <= yuv.chroma_v;
			item_s1.end_of_line  <= eol;
			item_s1.end_of_frame <= eof;
		end
	end

	assign out_valid = valid_s1;

	always_comb begin
		out_item = item_s1;
		if (odd_s1) begin
			out_item.chroma_u = chroma_rd_q[15:8];
			out_item.chroma_v = chroma_rd_q[7:0];
		end
	end

endmodule

// ----- design/y2b_fifo.sv -----
// Short queue of resolved pairs between the front end and the conversion pipeline.
// Depends on y2b_pkg.
module y2b_fifo import y2b_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_valid,
	output logic       wr_ready,
	input  pair_item_t wr_item,
	output logic       rd_valid,
	input  logic       rd_ready,
	output pair_item_t rd_item
);

	localparam int PW = $clog2(FIFO_DEPTH);

	pair_item_t    entry_q [FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;
	logic          do_wr;
	logic          do_rd;

	assign wr_ready = (count_q != (PW+1)'(FIFO_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_item  = entry_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (do_rd) rd_ptr_q <= rd_ptr_q + PW'(1);
			if (do_wr && !do_rd) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

endmodule

// ----- design/y2b_back.sv -----
// Back end: two-stage BT.601 integer conversion with clamping and output register.
// Depends on y2b_pkg.
module y2b_back import y2b_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  pair_item_t in_item,
	output logic       empty,
	input  logic       pop,
	output bgr_item_t  bgr
);

	localparam int SUM_W = 20;

	localparam logic signed [SUM_W-1:0] Y_OFFSET   = SUM_W'(16);
	localparam logic signed [SUM_W-1:0] CHROMA_MID = SUM_W'(128);
	localparam logic signed [SUM_W-1:0] ROUND      = SUM_W'(128);
	localparam logic signed [SUM_W-1:0] K_Y        = SUM_W'(298);
	localparam logic signed [SUM_W-1:0] K_RV       = SUM_W'(409);
	localparam logic signed [SUM_W-1:0] K_GU       = SUM_W'(100);
	localparam logic signed [SUM_W-1:0] K_GV       = SUM_W'(208);
	localparam logic signed [SUM_W-1:0] K_BU       = SUM_W'(516);

	function automatic logic signed [SUM_W-1:0] luma_term(input logic [7:0] y);
		logic signed [SUM_W-1:0] ys;
		ys = signed'(SUM_W'(y)) - Y_OFFSET;
		return ys * K_Y;
	endfunction

	function automatic logic signed [SUM_W-1:0] centered(input logic [7:0] c);
		return signed'(SUM_W'(c)) - CHROMA_MID;
	endfunction

	// Floor shift by 8, clamp to 0..255
	function automatic logic [7:0] clamp_pixel(input logic signed [SUM_W-1:0] s);
		if (s[SUM_W-1]) begin
			return 8'd0;
		end else if (|s[SUM_W-2:16]) begin
			return 8'hFF;
		end else begin
			return s[15:8];
		end
	endfunction

	logic                    valid_s1;
	logic signed [SUM_W-1:0] c0_s1;
	logic signed [SUM_W-1:0] c1_s1;
	logic signed [SUM_W-1:0] bu_s1;
	logic signed [SUM_W-1:0] gu_s1;
	logic signed [SUM_W-1:0] gv_s1;
	logic signed [SUM_W-1:0] rv_s1;
	logic                    eol_s1;
	logic                    eof_s1;

	logic                    valid_s2;
	bgr_item_t               bgr_s2;

	logic                    ready_s1;
	logic                    ready_s2;
	logic                    adv_s1;
	logic                    adv_s2;
	logic signed [SUM_W-1:0] d_val;
	logic signed [SUM_W-1:0] e_val;

	assign ready_s2 = !valid_s2 || pop;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;
	assign adv_s1   = in_valid && ready_s1;
	assign adv_s2   = valid_s1 && ready_s2;

	assign d_val = centered(in_item.chroma_u);
	assign e_val = centered(in_item.chroma_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			c0_s1  <= luma_term(in_item.luma_first);
			c1_s1  <= luma_term(in_item.luma_second);
			bu_s1  <= d_val * K_BU;
			gu_s1  <= d_val * K_GU;
			gv_s1  <= e_val * K_GV;
			rv_s1  <= e_val * K_RV;
			eol_s1 <= in_item.end_of_line;
			eof_s1 <= in_item.end_of_frame;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			bgr_s2.blue_first   <= clamp_pixel(c0_s1 + bu_s1 + ROUND);
			bgr_s2.green_first  <= clamp_pixel(c0_s1 - gu_s1 - gv_s1 + ROUND);
			bgr_s2.red_first    <= clamp_pixel(c0_s1 + rv_s1 + ROUND);
			bgr_s2.blue_second  <= clamp_pixel(c1_s1 + bu_s1 + ROUND);
			bgr_s2.green_second <= clamp_pixel(c1_s1 - gu_s1 - gv_s1 + ROUND);
			bgr_s2.red_second   <= clamp_pixel(c1_s1 + rv_s1 + ROUND);
			bgr_s2.end_of_line  <= eol_s1;
			bgr_s2.end_of_frame <= eof_s1;
		end
	end

	assign empty = !valid_s2;
	assign bgr   = bgr_s2;

endmodule

// ----- design/yuv420_to_bgr_converter.sv -----
// Raster-order YUV 4:2:0 to BGR converter, top level.
// Depends on y2b_pkg, y2b_front, y2b_fifo and y2b_back.
//
// Input queue: an item (two luma samples plus U and V) enters at an edge with
// push high and full low. Items arrive in raster order, two pixels per item;
// the chroma of even rows is kept in a line store of MAX_PAIRS entries and
// reused for the following odd row, whose own chroma fields are ignored.
// Result queue: while empty is low, the oldest BGR pair is on bgr; pop takes it.
// Configuration: cfg_we writes cfg_data to register cfg_index (0: pairs per
// line, 1: frame height); write only while no item is in flight.
// Throughput is one item per clock while pop keeps up. A result passes, after the
// edge that accepts its item, through the front register, four-entry queue,
// multiply stage, then sum/clamp stage which is also the output register.
// When pop stays low the back end fills, then the queue, and full rises; the
// front keeps taking items until the queue is full.
// Reset clears the position counters and empties every stage and the queue;
// registers return to 320 pairs and 480 lines. The line store is not cleared.
module yuv420_to_bgr_converter import y2b_pkg::*; #(
	parameter int MAX_PAIRS = MAX_PAIRS_DEF,
	parameter int MAX_LINES = MAX_LINES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 push,
	output logic                 full,
	input  yuv_item_t            yuv,
	output logic                 empty,
	input  logic                 pop,
	output bgr_item_t            bgr
);

	logic       front_valid;
	logic       front_ready;
	pair_item_t front_item;
	logic       back_valid;
	logic       back_ready;
	pair_item_t back_item;

	y2b_front #(
		.MAX_PAIRS (MAX_PAIRS),
		.MAX_LINES (MAX_LINES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.yuv       (yuv),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_item  (front_item)
	);

	y2b_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.wr_item  (front_item),
		.rd_valid (back_valid),
		.rd_ready (back_ready),
		.rd_item  (back_item)
	);

	y2b_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (back_valid),
		.in_ready (back_ready),
		.in_item  (back_item),
		.empty    (empty),
		.pop      (pop),
		.bgr      (bgr)
	);

`ifndef SYNTHESIS
	a_eof_has_eol: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (!bgr.end_of_frame || bgr.end_of_line))
		else $error("end of frame without end of line");

	a_full_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a preceding item");
`endif

endmodule

// ----- verif/yuv420_to_bgr_converter_test.sv -----
// Self-checking test of yuv420_to_bgr_converter: directed corners, then random frames.
// A scoreboard class predicts every BGR pair from the accepted YUV items.
// Depends on y2b_pkg and the converter RTL.
module yuv420_to_bgr_converter_test;
	import y2b_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int REPORT_LIMIT = 10;

	class bgr_scoreboard;
		logic [PPL_W-1:0] pairs_reg;
		logic [FH_W-1:0]  height_reg;
		int unsigned      column;
		int unsigned      row;
		logic [7:0]       u_store [MAX_PAIRS_DEF];
		logic [7:0]       v_store [MAX_PAIRS_DEF];
		bgr_item_t        expected_pixels [$];
		int               mismatches;

		function new();
			pairs_reg = PPL_W'(PPL_RESET);
			height_reg = FH_W'(FH_RESET);
			column = 0;
			row = 0;
			mismatches = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_PAIRS_PER_LINE: pairs_reg = data[PPL_W-1:0];
				REG_FRAME_HEIGHT:   height_reg = data[FH_W-1:0];
				default: ;
			endcase
		endfunction

		// Out-of-range settings saturate; zero acts as one.
		function int unsigned line_pairs();
			if (pairs_reg == 0) return 1;
			if (pairs_reg > MAX_PAIRS_DEF) return MAX_PAIRS_DEF;
			return pairs_reg;
		endfunction

		function int unsigned frame_lines();
			if (height_reg == 0) return 1;
			if (height_reg > MAX_LINES_DEF) return MAX_LINES_DEF;
			return height_reg;
		endfunction

		function logic [7:0] clamp_channel(int sum);
			int q;
			q = sum >>> 8;
			if (q < 0) return 8'd0;
			if (q > 255) return 8'd255;
			return q[7:0];
		endfunction

		function void convert_pixel(logic [7:0] y, int d, int e,
				output logic [7:0] b, output logic [7:0] g, output logic [7:0] r);
			int luma;
			int c;
			luma = int'(y);
			c = (luma - 16) * 298;
			b = clamp_channel(c + 516 * d + 128);
			g = clamp_channel(c - 100 * d - 208 * e + 128);
			r = clamp_channel(c + 409 * e + 128);
		endfunction

		function void note_pair(yuv_item_t item);
			int unsigned pairs;
			int unsigned lines;
			int unsigned slot;
			logic [7:0]  u;
			logic [7:0]  v;
			bgr_item_t   px;
			pairs = line_pairs();
			lines = frame_lines();
			slot = (column > pairs - 1) ? pairs - 1 : column;
			// Even rows take fresh chroma and store it; odd rows reuse it.
			if (row[0] == 1'b0) begin
				u = item.chroma_u;
				v = item.chroma_v;
				u_store[slot] = u;
				v_store[slot] = v;
			end else begin
				u = u_store[slot];
				v = v_store[slot];
			end
			convert_pixel(item.luma_first, int'(u) - 128, int'(v) - 128,
				px.blue_first, px.green_first, px.red_first);
			convert_pixel(item.luma_second, int'(u) - 128, int'(v) - 128,
				px.blue_second, px.green_second, px.red_second);
			px.end_of_line = (column >= pairs - 1);
			px.end_of_frame = px.end_of_line && (row >= lines - 1);
			if (px.end_of_line) begin
				column = 0;
				row = px.end_of_frame ? 0 : row + 1;
			end else begin
				column++;
			end
			expected_pixels.push_back(px);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				if (mismatches < REPORT_LIMIT)
					$display("mismatch %s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_pixels(bgr_item_t got);
			bgr_item_t want;
			if (expected_pixels.size() == 0) begin
				if (mismatches < REPORT_LIMIT)
					$display("unexpected pixel pair %h", got);
				mismatches++;
				return;
			end
			want = expected_pixels.pop_front();
			compare_field("blue_first", want.blue_first, got.blue_first);
			compare_field("green_first", want.green_first, got.green_first);
			compare_field("red_first", want.red_first, got.red_first);
			compare_field("blue_second", want.blue_second, got.blue_second);
			compare_field("green_second", want.green_second, got.green_second);
			compare_field("red_second", want.red_second, got.red_second);
			compare_field("end_of_line", want.end_of_line, got.end_of_line);
			compare_field("end_of_frame", want.end_of_frame, got.end_of_frame);
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 push = 1'b0;
	logic                 full;
	yuv_item_t            yuv = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	bgr_item_t            bgr;

	bgr_scoreboard bgr_sb = new();
	int stall_pct = 0;
	int hold_request = 0;
	int quiet_cycles = 0;

	yuv420_to_bgr_converter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.yuv(yuv),
		.empty(empty),
		.pop(pop),
		.bgr(bgr)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				bgr_sb.set_reg(cfg_reg_t'(cfg_index), cfg_data);
			if (push && !full)
				bgr_sb.note_pair(yuv);
			if (pop && !empty)
				bgr_sb.check_pixels(bgr);
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Result side: a requested hold-off keeps pop low, otherwise stall at random.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else begin
				pop <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic logic [7:0] random_sample();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic yuv_item_t make_pair(int y1, int y2, int u, int v);
		yuv_item_t item;
		item.luma_first = 8'(y1);
		item.luma_second = 8'(y2);
		item.chroma_u = 8'(u);
		item.chroma_v = 8'(v);
		return item;
	endfunction

	function automatic yuv_item_t random_pair();
		return make_pair(random_sample(), random_sample(), random_sample(), random_sample());
	endfunction

	// Offer one item, with random idle cycles ahead of it; return once accepted.
	task automatic send_pair(yuv_item_t item, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		yuv <= item;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	// Drop push and wait until every predicted pair has come out.
	task automatic wait_drained();
		push <= 1'b0;
		do
			@(posedge clk);
		while (bgr_sb.pending() != 0);
	endtask

	task automatic program_reg(cfg_reg_t idx, int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int idle_mode [4][2];
		int pairs;
		int lines;
		int frame;
		int target;
		int count;
		int mode;

		idle_mode = '{'{0, 0}, '{53, 0}, '{0, 53}, '{18, 18}};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry: first row, field extremes and neutral chroma.
		send_pair(make_pair(0, 255, 0, 255), 0);
		send_pair(make_pair(255, 0, 255, 0), 0);
		send_pair(make_pair(16, 235, 128, 128), 0);
		send_pair(make_pair(255, 255, 255, 255), 0);
		send_pair(make_pair(0, 0, 0, 0), 0);
		wait_drained();
		// Shrink the line while the column is past its new end: the line closes.
		program_reg(REG_PAIRS_PER_LINE, 3);
		send_pair(make_pair(128, 64, 90, 240), 0);
		// Odd row: chroma fields are ignored.
		send_pair(make_pair(200, 30, 0, 0), 0);
		send_pair(make_pair(81, 145, 255, 255), 0);
		wait_drained();
		// Shrink the frame below the current row: the frame closes on this line.
		program_reg(REG_FRAME_HEIGHT, 1);
		send_pair(make_pair(235, 16, 17, 19), 0);
		wait_drained();
		// Zero settings act as one pair and one line.
		program_reg(REG_PAIRS_PER_LINE, 0);
		program_reg(REG_FRAME_HEIGHT, 0);
		send_pair(make_pair(1, 2, 254, 1), 0);
		send_pair(make_pair(128, 127, 128, 127), 0);
		send_pair(make_pair(170, 85, 170, 85), 0);
		wait_drained();
		// Settings beyond the maximum saturate.
		program_reg(REG_PAIRS_PER_LINE, 1023);
		program_reg(REG_FRAME_HEIGHT, 2047);
		repeat (4)
			send_pair(random_pair(), 0);
		wait_drained();
		program_reg(REG_PAIRS_PER_LINE, 2);
		send_pair(random_pair(), 0);
		wait_drained();
		program_reg(REG_FRAME_HEIGHT, 2);
		send_pair(random_pair(), 0);
		send_pair(random_pair(), 0);
		wait_drained();

		// Random part: whole frames per phase, so every odd row finds stored chroma.
		for (int p = 0; p < 10; p++) begin
			if (p == 0) begin
				pairs = MAX_PAIRS_DEF;
				lines = 1;
				target = 500;
				mode = 0;
			end else if (p == 1) begin
				pairs = 1;
				lines = MAX_LINES_DEF;
				target = 1000;
				mode = 3;
			end else begin
				pairs = $urandom_range(12, 1);
				lines = $urandom_range(6, 1);
				target = 8;
				mode = (p - 2) % 4;
			end
			program_reg(REG_PAIRS_PER_LINE, pairs);
			program_reg(REG_FRAME_HEIGHT, lines);
			stall_pct = idle_mode[mode][1];
			// Hold the result side off long enough to back the block up into full.
			if (p == 0)
				hold_request = 80;
			frame = pairs * lines;
			count = ((target + frame - 1) / frame) * frame;
			for (int i = 0; i < count; i++)
				send_pair(random_pair(), idle_mode[mode][0]);
			wait_drained();
		end

		stall_pct = 0;
		repeat (10) @(posedge clk);
		if (bgr_sb.mismatches == 0 && bgr_sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
